@@ rtl/adts_pkg.sv @@
// adts_pkg: shared types, status codes and rate table for the ADTS deframer
// used by adts_stream_deframer; no dependencies
package adts_pkg;

  localparam int unsigned SAMPLES_PER_FRAME_DEF = 1024;
  localparam int unsigned NUM_RATES             = 13;
  localparam int unsigned HDR_LEN               = 7;
  localparam logic [12:0] MAX_FRAME_RESET       = 13'd2048;

  localparam logic [7:0] SYNC_BYTE0  = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SYNC   = 2'd1;
  localparam logic [1:0] STATUS_FORMAT = 2'd2;

  localparam int unsigned RATE_HZ [NUM_RATES] = '{
    96000, 88200, 64000, 48000, 44100, 32000,
    24000, 22050, 16000, 12000, 11025, 8000, 7350
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] frame_bytes;
    logic [31:0] timestamp_ms;
    logic [3:0]  rate_index;
    logic [2:0]  channel_config;
    logic [31:0] frames_done;
    logic        is_last_frame;
  } out_t;

endpackage

@@ rtl/adts_stream_deframer.sv @@
// adts_stream_deframer: ADTS header parser and frame descriptor generator
// depends on adts_pkg (types, status codes, rate table)
//
//  channel | ports                         | direction | moves
//  --------+-------------------------------+-----------+--------------------------
//  input   | in_valid, in_ready, in_data   | in        | one stream byte a request
//  result  | out_valid, out_ready, out_data| out       | one frame descriptor
//  config  | cfg_we, cfg_wdata             | in        | max_frame_bytes write
//
// one byte is taken every cycle with in_ready high; state update and descriptor
// are formed in the cycle the byte is accepted and the descriptor shows up in the
// output register on the next cycle. in_ready drops only while a descriptor sits
// unread, and a single output register is the only buffer.
// reset is synchronous, active low; stream_start clears the stream state.
module adts_stream_deframer #(
  parameter int unsigned SAMPLES_PER_FRAME = adts_pkg::SAMPLES_PER_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  adts_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output adts_pkg::out_t    out_data,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  localparam int unsigned NUM = SAMPLES_PER_FRAME * 1000;

  // per-rate ms quotient and remainder of one frame, fixed at elaboration
  localparam logic [31:0] QUOT [adts_pkg::NUM_RATES] = '{
    32'(NUM / adts_pkg::RATE_HZ[0]),  32'(NUM / adts_pkg::RATE_HZ[1]),
    32'(NUM / adts_pkg::RATE_HZ[2]),  32'(NUM / adts_pkg::RATE_HZ[3]),
    32'(NUM / adts_pkg::RATE_HZ[4]),  32'(NUM / adts_pkg::RATE_HZ[5]),
    32'(NUM / adts_pkg::RATE_HZ[6]),  32'(NUM / adts_pkg::RATE_HZ[7]),
    32'(NUM / adts_pkg::RATE_HZ[8]),  32'(NUM / adts_pkg::RATE_HZ[9]),
    32'(NUM / adts_pkg::RATE_HZ[10]), 32'(NUM / adts_pkg::RATE_HZ[11]),
    32'(NUM / adts_pkg::RATE_HZ[12])
  };
  localparam logic [16:0] REM [adts_pkg::NUM_RATES] = '{
    17'(NUM % adts_pkg::RATE_HZ[0]),  17'(NUM % adts_pkg::RATE_HZ[1]),
    17'(NUM % adts_pkg::RATE_HZ[2]),  17'(NUM % adts_pkg::RATE_HZ[3]),
    17'(NUM % adts_pkg::RATE_HZ[4]),  17'(NUM % adts_pkg::RATE_HZ[5]),
    17'(NUM % adts_pkg::RATE_HZ[6]),  17'(NUM % adts_pkg::RATE_HZ[7]),
    17'(NUM % adts_pkg::RATE_HZ[8]),  17'(NUM % adts_pkg::RATE_HZ[9]),
    17'(NUM % adts_pkg::RATE_HZ[10]), 17'(NUM % adts_pkg::RATE_HZ[11]),
    17'(NUM % adts_pkg::RATE_HZ[12])
  };

  phase_t         phase_r, phase_nxt;
  logic [2:0]     hpos_r, hpos_nxt;
  logic [7:0]     hstore_r [6];
  logic [12:0]    pleft_r, pleft_nxt;
  logic [12:0]    clen_r, clen_nxt;
  logic           fknown_r, fknown_nxt;
  logic [3:0]     srate_r, srate_nxt;
  logic [2:0]     schan_r, schan_nxt;
  logic [31:0]    fcnt_r, fcnt_nxt;
  logic [31:0]    tms_r, tms_nxt;
  logic [16:0]    trem_r, trem_nxt;
  logic [12:0]    maxlen_r;
  logic           out_valid_r, out_valid_nxt;
  adts_pkg::out_t out_r, out_nxt;

  logic           acc;
  logic           hs_we;
  logic           res_vld;
  adts_pkg::out_t res;

  // cleared view of state when stream_start is set
  phase_t         ph;
  logic [2:0]     pos;
  logic [12:0]    pl;
  logic           fk;
  logic [3:0]     rt;
  logic [2:0]     chn;
  logic [31:0]    cnt;
  logic [31:0]    tms;
  logic [16:0]    trem;

  logic [3:0]     hdr_ri;
  logic [2:0]     hdr_ch;
  logic [12:0]    hdr_len;
  logic           sync_ok;
  logic [17:0]    rem_sum;
  logic [17:0]    rate_w;
  logic           eop;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign eop       = in_data.stream_end;

  assign hdr_ri  = hstore_r[2][5:2];
  assign hdr_ch  = {hstore_r[2][0], hstore_r[3][7:6]};
  assign hdr_len = {hstore_r[3][1:0], hstore_r[4], hstore_r[5][7:5]};
  assign sync_ok = (hstore_r[0] == adts_pkg::SYNC_BYTE0) &&
                   (hstore_r[1][7:4] == adts_pkg::SYNC_NIBBLE);

  always_comb begin
    ph   = in_data.stream_start ? PH_HEADER : phase_r;
    pos  = in_data.stream_start ? 3'd0      : hpos_r;
    pl   = in_data.stream_start ? 13'd0     : pleft_r;
    fk   = in_data.stream_start ? 1'b0      : fknown_r;
    rt   = in_data.stream_start ? 4'd0      : srate_r;
    chn  = in_data.stream_start ? 3'd0      : schan_r;
    cnt  = in_data.stream_start ? 32'd0     : fcnt_r;
    tms  = in_data.stream_start ? 32'd0     : tms_r;
    trem = in_data.stream_start ? 17'd0     : trem_r;

    phase_nxt  = ph;
    hpos_nxt   = pos;
    pleft_nxt  = pl;
    clen_nxt   = in_data.stream_start ? 13'd0 : clen_r;
    fknown_nxt = fk;
    srate_nxt  = rt;
    schan_nxt  = chn;
    fcnt_nxt   = cnt;
    tms_nxt    = tms;
    trem_nxt   = trem;
    hs_we      = 1'b0;
    res_vld    = 1'b0;
    rem_sum    = '0;
    rate_w     = '0;

    res                = '0;
    res.timestamp_ms   = tms;
    res.frames_done    = cnt;
    res.status         = adts_pkg::STATUS_SYNC;

    case (ph)
      PH_HEADER: begin
        if (pos < 3'd6) begin
          hs_we    = 1'b1;
          hpos_nxt = pos + 3'd1;
          if (eop) phase_nxt = PH_HALT;
        end else begin
          hpos_nxt = 3'd0;
          if (!sync_ok) begin
            res_vld    = 1'b1;
            res.status = adts_pkg::STATUS_SYNC;
            phase_nxt  = PH_HALT;
          end else if (!fk && (hdr_ri >= 4'(adts_pkg::NUM_RATES) || hdr_ch == 3'd0)) begin
            res_vld    = 1'b1;
            res.status = adts_pkg::STATUS_FORMAT;
            phase_nxt  = PH_HALT;
          end else begin
            if (!fk) begin
              srate_nxt  = hdr_ri;
              schan_nxt  = hdr_ch;
              fknown_nxt = 1'b1;
            end
            clen_nxt = hdr_len;
            if (hdr_len <= 13'(adts_pkg::HDR_LEN) || hdr_len > maxlen_r) begin
              res_vld    = 1'b1;
              res.status = adts_pkg::STATUS_SYNC;
              phase_nxt  = PH_HALT;
            end else begin
              pleft_nxt = hdr_len - 13'(adts_pkg::HDR_LEN);
              phase_nxt = eop ? PH_HALT : PH_PAYLOAD;
            end
          end
        end
        // error descriptors carry the format as it stands after this header
        res.rate_index     = srate_nxt;
        res.channel_config = schan_nxt;
      end
      PH_PAYLOAD: begin
        res.rate_index     = rt;
        res.channel_config = chn;
        if (pl > 13'd1) begin
          pleft_nxt = pl - 13'd1;
          if (eop) phase_nxt = PH_HALT;
        end else begin
          pleft_nxt         = 13'd0;
          res_vld           = 1'b1;
          res.status        = adts_pkg::STATUS_OK;
          res.frame_bytes   = clen_nxt;
          res.is_last_frame = eop;
          if (cnt != 32'hFFFF_FFFF) fcnt_nxt = cnt + 32'd1;
          if (eop) begin
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_HEADER;
            hpos_nxt  = 3'd0;
            if (rt < 4'(adts_pkg::NUM_RATES)) begin
              rate_w  = 18'(adts_pkg::RATE_HZ[rt]);
              rem_sum = {1'b0, trem} + {1'b0, REM[rt]};
              tms_nxt = tms + QUOT[rt];
              if (rem_sum >= rate_w) begin
                rem_sum = rem_sum - rate_w;
                tms_nxt = tms_nxt + 32'd1;
              end
              trem_nxt = rem_sum[16:0];
            end
          end
        end
      end
      default: begin
        res.rate_index     = rt;
        res.channel_config = chn;
      end
    endcase

    if (acc) begin
      out_valid_nxt = res_vld;
      out_nxt       = res_vld ? res : out_r;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_nxt       = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hpos_r      <= 3'd0;
      pleft_r     <= 13'd0;
      clen_r      <= 13'd0;
      fknown_r    <= 1'b0;
      srate_r     <= 4'd0;
      schan_r     <= 3'd0;
      fcnt_r      <= 32'd0;
      tms_r       <= 32'd0;
      trem_r      <= 17'd0;
      maxlen_r    <= adts_pkg::MAX_FRAME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        phase_r  <= phase_nxt;
        hpos_r   <= hpos_nxt;
        pleft_r  <= pleft_nxt;
        clen_r   <= clen_nxt;
        fknown_r <= fknown_nxt;
        srate_r  <= srate_nxt;
        schan_r  <= schan_nxt;
        fcnt_r   <= fcnt_nxt;
        tms_r    <= tms_nxt;
        trem_r   <= trem_nxt;
      end
      if (cfg_we) maxlen_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  // header bytes, no reset: always written before the parse reads them
  always_ff @(posedge clk) begin
    if (acc && hs_we) hstore_r[pos] <= in_data.data_byte;
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pleft_r != 13'd0)
    else $error("payload phase with nothing left to count");

  a_hpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    hpos_r <= 3'd6)
    else $error("header position past seventh byte");

  a_format_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fknown_r |-> (srate_r < 4'(adts_pkg::NUM_RATES) && schan_r != 3'd0))
    else $error("stored format out of range");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res_vld && res.status != adts_pkg::STATUS_OK |=> phase_r == PH_HALT)
    else $error("error descriptor did not halt the block");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != adts_pkg::STATUS_OK |->
      out_r.frame_bytes == 13'd0 && !out_r.is_last_frame)
    else $error("error descriptor carries frame fields");

endmodule

@@ test/adts_stream_deframer_tb.sv @@
// adts_stream_deframer_tb: self-checking bench for the ADTS byte stream deframer
// drives byte requests and max-length writes, predicts descriptors and checks them
// depends on adts_pkg and adts_stream_deframer
`timescale 1ns / 100ps

module adts_stream_deframer_tb;

  localparam int unsigned FRAME_SAMPLES = adts_pkg::SAMPLES_PER_FRAME_DEF;
  localparam int unsigned PHASE_ITEMS   = 110;
  localparam int unsigned LONG_FRAME    = 1031;
  localparam int unsigned LIMIT_CYCLES  = 1500000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_PRINTED   = 100;

  typedef enum logic [1:0] {SEEK_HDR, IN_PAYLOAD, HALTED} deframe_phase_t;

  typedef struct {
    adts_pkg::in_t  d;
    bit             typed;
    adts_pkg::out_t want;
  } dir_row_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  adts_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  adts_pkg::out_t out_data;
  logic           cfg_we    = 1'b0;
  logic [12:0]    cfg_wdata = '0;

  // typed expectation travelling with the current request
  bit             req_typed = 1'b0;
  adts_pkg::out_t req_want  = '0;

  bit             calm;
  int unsigned    sent_bytes;
  int unsigned    mismatch_count;
  int unsigned    cycle_count;
  int unsigned    ready_stall;
  adts_pkg::out_t pending_desc[$];
  dir_row_t       dir_rows[$];

  // predictor state
  deframe_phase_t parse_phase;
  logic [2:0]     hdr_pos;
  logic [7:0]     hdr_bytes [0:5];
  logic [12:0]    bytes_left;
  logic [12:0]    frm_bytes;
  bit             fmt_known;
  logic [3:0]     sf_index;
  logic [2:0]     chan_cfg;
  logic [31:0]    frame_cnt;
  logic [31:0]    clock_ms;
  int unsigned    clock_rem;
  logic [12:0]    frame_limit;

  adts_stream_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cycle_count++;

  function automatic adts_pkg::out_t make_desc(input logic [1:0] status,
                                               input logic [12:0] nbytes,
                                               input logic [31:0] ts, input logic [3:0] ri,
                                               input logic [2:0] ch, input logic [31:0] done,
                                               input logic last);
    adts_pkg::out_t r;
    r.status         = status;
    r.frame_bytes    = nbytes;
    r.timestamp_ms   = ts;
    r.rate_index     = ri;
    r.channel_config = ch;
    r.frames_done    = done;
    r.is_last_frame  = last;
    return r;
  endfunction

  function automatic void clear_stream();
    parse_phase = SEEK_HDR;
    hdr_pos     = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    bytes_left  = '0;
    frm_bytes   = '0;
    fmt_known   = 1'b0;
    sf_index    = '0;
    chan_cfg    = '0;
    frame_cnt   = '0;
    clock_ms    = '0;
    clock_rem   = 0;
  endfunction

  // error descriptor; the deframer stops until the next stream start
  function automatic adts_pkg::out_t fault(input logic [1:0] status);
    parse_phase = HALTED;
    return make_desc(status, 13'd0, clock_ms, sf_index, chan_cfg, frame_cnt, 1'b0);
  endfunction

  function automatic bit deframe_byte(input adts_pkg::in_t d, output adts_pkg::out_t desc);
    logic [3:0]  sfi;
    logic [2:0]  ch;
    int unsigned hz;
    int unsigned num;
    desc = '0;
    if (d.stream_start) clear_stream();
    case (parse_phase)
      SEEK_HDR: begin
        if (hdr_pos < 3'd6) begin
          hdr_bytes[hdr_pos] = d.data_byte;
          hdr_pos = hdr_pos + 3'd1;
          if (d.stream_end) parse_phase = HALTED;
          return 1'b0;
        end
        // seventh byte completes the header, it is not stored
        hdr_pos = '0;
        if (hdr_bytes[0] != adts_pkg::SYNC_BYTE0 ||
            hdr_bytes[1][7:4] != adts_pkg::SYNC_NIBBLE) begin
          desc = fault(adts_pkg::STATUS_SYNC);
          return 1'b1;
        end
        if (!fmt_known) begin
          sfi = hdr_bytes[2][5:2];
          ch  = {hdr_bytes[2][0], hdr_bytes[3][7:6]};
          if (sfi >= 4'(adts_pkg::NUM_RATES) || ch == 3'd0) begin
            desc = fault(adts_pkg::STATUS_FORMAT);
            return 1'b1;
          end
          sf_index  = sfi;
          chan_cfg  = ch;
          fmt_known = 1'b1;
        end
        frm_bytes = {hdr_bytes[3][1:0], hdr_bytes[4], hdr_bytes[5][7:5]};
        if (frm_bytes <= 13'(adts_pkg::HDR_LEN) || frm_bytes > frame_limit) begin
          desc = fault(adts_pkg::STATUS_SYNC);
          return 1'b1;
        end
        bytes_left  = frm_bytes - 13'(adts_pkg::HDR_LEN);
        parse_phase = d.stream_end ? HALTED : IN_PAYLOAD;
        return 1'b0;
      end
      IN_PAYLOAD: begin
        if (bytes_left > 13'd1) begin
          bytes_left = bytes_left - 13'd1;
          if (d.stream_end) parse_phase = HALTED;
          return 1'b0;
        end
        bytes_left = '0;
        desc = make_desc(adts_pkg::STATUS_OK, frm_bytes, clock_ms, sf_index, chan_cfg,
                         frame_cnt, d.stream_end);
        if (frame_cnt != 32'hFFFF_FFFF) frame_cnt = frame_cnt + 32'd1;
        if (d.stream_end) begin
          parse_phase = HALTED;
        end else begin
          case (sf_index)
            4'd0:    hz = 96000;
            4'd1:    hz = 88200;
            4'd2:    hz = 64000;
            4'd3:    hz = 48000;
            4'd4:    hz = 44100;
            4'd5:    hz = 32000;
            4'd6:    hz = 24000;
            4'd7:    hz = 22050;
            4'd8:    hz = 16000;
            4'd9:    hz = 12000;
            4'd10:   hz = 11025;
            4'd11:   hz = 8000;
            default: hz = 7350;
          endcase
          // exact time: whole ms per frame plus a carried remainder
          num       = FRAME_SAMPLES * 1000;
          clock_ms  = clock_ms + num / hz;
          clock_rem = clock_rem + num % hz;
          if (clock_rem >= hz) begin
            clock_rem = clock_rem - hz;
            clock_ms  = clock_ms + 32'd1;
          end
          parse_phase = SEEK_HDR;
          hdr_pos     = '0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report($sformatf("%s is %0h, predicted %0h", name, got, want));
  endtask

  always @(posedge clk) begin : scoreboard
    adts_pkg::out_t desc;
    adts_pkg::out_t want;
    if (!rst_n) begin
      clear_stream();
      frame_limit = adts_pkg::MAX_FRAME_RESET;
    end else begin
      if (in_valid && in_ready && deframe_byte(in_data, desc))
        pending_desc.push_back(req_typed ? req_want : desc);
      if (out_valid && out_ready) begin
        if (pending_desc.size() == 0) begin
          report("descriptor with none pending");
        end else begin
          want = pending_desc.pop_front();
          check_field("status", 64'(out_data.status), 64'(want.status));
          check_field("frame_bytes", 64'(out_data.frame_bytes), 64'(want.frame_bytes));
          check_field("timestamp_ms", 64'(out_data.timestamp_ms), 64'(want.timestamp_ms));
          check_field("rate_index", 64'(out_data.rate_index), 64'(want.rate_index));
          check_field("channel_config", 64'(out_data.channel_config),
                      64'(want.channel_config));
          check_field("frames_done", 64'(out_data.frames_done), 64'(want.frames_done));
          check_field("is_last_frame", 64'(out_data.is_last_frame),
                      64'(want.is_last_frame));
        end
      end
      if (cfg_we) frame_limit = cfg_wdata;
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  always @(negedge clk) begin
    if (ready_stall != 0) begin
      out_ready <= 1'b0;
      ready_stall--;
    end else begin
      out_ready <= 1'b1;
      if (rst_n && $urandom_range(0, 3) == 0) ready_stall = pick_gap();
    end
  end

  task automatic send_byte(input adts_pkg::in_t d, input bit typed, input adts_pkg::out_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_data   <= d;
    req_typed <= typed;
    req_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit st, input bit en);
    adts_pkg::in_t d;
    d.data_byte    = b;
    d.stream_start = st;
    d.stream_end   = en;
    send_byte(d, 1'b0, '0);
    sent_bytes++;
  endtask

  task automatic add_row(input logic [7:0] b, input bit st, input bit en,
                         input bit typed, input adts_pkg::out_t want);
    dir_row_t row;
    row.d.data_byte    = b;
    row.d.stream_start = st;
    row.d.stream_end   = en;
    row.typed          = typed;
    row.want           = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic [12:0] pick_len();
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(0, 99);
    top = (frame_limit < 13'd48) ? 32'(frame_limit) : 48;
    if (frame_limit < 13'd8) return 13'($urandom);
    if (r < 75) return 13'($urandom_range(8, top));
    if (r < 80) return (frame_limit <= 13'd300) ? frame_limit : 13'($urandom_range(49, 300));
    if (r < 88) return 13'($urandom_range(0, 7));
    if (r < 95 && frame_limit != 13'h1FFF)
      return 13'($urandom_range(32'(frame_limit) + 1, 8191));
    return 13'($urandom_range(8, top));
  endfunction

  // one stream: a run of frames, with the occasional broken header or early end
  task automatic send_stream(input int unsigned forced_len);
    logic [3:0]  sfi;
    logic [2:0]  ch;
    logic [12:0] len;
    logic [7:0]  hdr [0:6];
    int unsigned nframes;
    int unsigned total;
    int unsigned cut_at;
    bit          bad;
    bit          sync_bad;
    bit          truncate;
    bit          end_last;
    calm     = ($urandom_range(0, 4) == 0);
    sfi      = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(13, 15))
                                            : 4'($urandom_range(0, 12));
    ch       = ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    nframes  = (forced_len != 0) ? 1 : $urandom_range(1, 6);
    truncate = ($urandom_range(0, 9) == 0);
    end_last = ($urandom_range(0, 4) != 0);
    for (int f = 0; f < nframes; f++) begin
      len = (forced_len != 0) ? 13'(forced_len) : pick_len();
      // format of later headers is not checked, so it may be anything
      if (f != 0) begin
        sfi = 4'($urandom);
        ch  = 3'($urandom);
      end
      sync_bad = ($urandom_range(0, 29) == 0);
      hdr[0] = (sync_bad && $urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 254)) : 8'hFF;
      hdr[1] = {((sync_bad && hdr[0] == 8'hFF) ? 4'($urandom_range(0, 14)) : 4'hF),
                4'($urandom)};
      hdr[2] = {2'($urandom), sfi, 1'($urandom), ch[2]};
      hdr[3] = {ch[1:0], 4'($urandom), len[12:11]};
      hdr[4] = len[10:3];
      hdr[5] = {len[2:0], 5'($urandom)};
      hdr[6] = 8'($urandom);
      bad    = sync_bad || (f == 0 && (sfi >= 4'(adts_pkg::NUM_RATES) || ch == 3'd0)) ||
               len <= 13'(adts_pkg::HDR_LEN) || len > frame_limit;
      total  = bad ? adts_pkg::HDR_LEN : 32'(len);
      cut_at = (truncate && f == nframes - 1) ? $urandom_range(0, total - 1) : total;
      for (int k = 0; k < total && k <= cut_at; k++)
        push_byte((k < adts_pkg::HDR_LEN) ? hdr[k] : 8'($urandom), f == 0 && k == 0,
                  k == cut_at || (f == nframes - 1 && end_last && k == total - 1));
      if (bad || cut_at < total) break;
    end
    // trailing bytes, ignored once the stream has stopped
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0, 1'($urandom));
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    stop_at = sent_bytes + budget;
    while (sent_bytes < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        calm = 1'b0;
        repeat ($urandom_range(1, 20))
          push_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      end else begin
        send_stream(0);
      end
    end
  endtask

  // registers change only once every request has drained
  task automatic write_limit(input logic [12:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_desc.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [12:0] limit_plan [0:4];
    // bad sync with a bad format as well: sync wins
    add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h0F, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h3C, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b1,
            make_desc(adts_pkg::STATUS_SYNC, 13'd0, 32'd0, 4'd0, 3'd0, 32'd0, 1'b0));
    // good sync, zero channels and zero length: format checked before length
    add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hF1, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b1,
            make_desc(adts_pkg::STATUS_FORMAT, 13'd0, 32'd0, 4'd0, 3'd0, 32'd0, 1'b0));
    // shortest frame at the top rate index, seven channels
    add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hF9, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h71, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hC0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h1F, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFC, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hA5, 1'b0, 1'b0, 1'b1,
            make_desc(adts_pkg::STATUS_OK, 13'd8, 32'd0, 4'd12, 3'd7, 32'd0, 1'b0));
    // stream ends inside the next header, then a byte that is ignored
    add_row(8'h55, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);

    limit_plan = '{13'h1FFF, 13'd8, 13'd0, 13'($urandom_range(9, 200)),
                   adts_pkg::MAX_FRAME_RESET};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].d, dir_rows[i].typed, dir_rows[i].want);
    run_random(PHASE_ITEMS);
    foreach (limit_plan[i]) begin
      write_limit(limit_plan[i]);
      // one long frame while the limit allows it
      if (limit_plan[i] == 13'h1FFF) send_stream(LONG_FRAME);
      run_random(PHASE_ITEMS);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_desc.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
